>>> design/mbb_pkg.sv
// shared constants and types for the masked 2x2 box blur
package mbb_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int FW_W      = 12;
   localparam int FH_W      = 16;
   localparam int WCMP_W    = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
   localparam int PIX_W     = 24;
   localparam int MASK_W    = 8;
   localparam int CSR_W     = 16;
   localparam int CHAN_W    = 8;
   localparam int SUM_W     = CHAN_W + 2;

   localparam logic [MASK_W-1:0] MASK_PASS     = 8'hFF;
   localparam logic [FW_W-1:0]   WIDTH_RESET   = 12'd640;
   localparam logic [FH_W-1:0]   HEIGHT_RESET  = 16'd480;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_reg_type;

   // window position of one pixel as seen at acceptance
   typedef struct packed {
      logic             interior;
      logic [COL_W-1:0] idx;
   } pos_type;

endpackage

>>> design/mbb_line_mem.sv
// previous-row line memory with registered read and write-to-read forwarding
module mbb_line_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [mbb_pkg::COL_W-1:0]   rd_addr,
   output logic [mbb_pkg::PIX_W-1:0]   rd_data,
   input  logic                        wr_en,
   input  logic [mbb_pkg::COL_W-1:0]   wr_addr,
   input  logic [mbb_pkg::PIX_W-1:0]   wr_data
);
   import mbb_pkg::*;

   logic [PIX_W-1:0] mem [MAX_WIDTH];
   logic [PIX_W-1:0] rd_ff;
   logic [PIX_W-1:0] fwd_data_ff;
   logic             fwd_ff;
   logic             fwd_in;

   // a read and a write to the same entry on one edge: take the new data
   assign fwd_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_ff;

endmodule

>>> design/mbb_scan.sv
// frame size registers and raster column / row counters
module mbb_scan (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [mbb_pkg::CSR_W-1:0]   csr_wr_data,
   input  logic                        advance,
   output mbb_pkg::pos_type            pos
);
   import mbb_pkg::*;

   logic [FW_W-1:0]   width_ff;
   logic [FH_W-1:0]   height_ff;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [FH_W-1:0]   row_ff;
   logic [FH_W-1:0]   row_in;
   logic [WCMP_W-1:0] w_eff;
   logic [WCMP_W-1:0] col_next;
   logic [FH_W:0]     h_eff;
   logic [FH_W:0]     row_next;
   logic              col_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_FRAME_WIDTH:  width_ff  <= csr_wr_data[FW_W-1:0];
            REG_FRAME_HEIGHT: height_ff <= csr_wr_data[FH_W-1:0];
         endcase
      end
   end

   // zero size counts as one, width saturates at the line memory depth
   always_comb begin
      priority if (width_ff == '0) begin
         w_eff = WCMP_W'(1);
      end else if (WCMP_W'(width_ff) > WCMP_W'(MAX_WIDTH)) begin
         w_eff = WCMP_W'(MAX_WIDTH);
      end else begin
         w_eff = WCMP_W'(width_ff);
      end
      h_eff    = (height_ff == '0) ? (FH_W+1)'(1) : {1'b0, height_ff};
      col_next = WCMP_W'(col_ff) + WCMP_W'(1);
      row_next = {1'b0, row_ff} + (FH_W+1)'(1);
      col_last = col_next >= w_eff;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (col_last) begin
            col_in = '0;
            row_in = (row_next >= h_eff) ? '0 : row_next[FH_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign pos.interior = (row_ff != '0) && (row_next < h_eff) &&
                         (col_ff != '0) && !col_last;
   assign pos.idx      = col_ff;

endmodule

>>> design/mbb_blur.sv
// 2x2 window sum, divide by four and pass-through selection
module mbb_blur (
   input  logic [mbb_pkg::PIX_W-1:0] upleft,
   input  logic [mbb_pkg::PIX_W-1:0] up,
   input  logic [mbb_pkg::PIX_W-1:0] left,
   input  logic [mbb_pkg::PIX_W-1:0] cur,
   input  logic [mbb_pkg::PIX_W-1:0] pixel,
   input  logic                      interior,
   output logic [mbb_pkg::PIX_W-1:0] result
);
   import mbb_pkg::*;

   localparam int NCH = PIX_W / CHAN_W;

   logic [SUM_W-1:0]  sum [NCH];
   logic [PIX_W-1:0]  avg;
   logic              any_set;

   always_comb begin
      any_set = 1'b0;
      for (int c = 0; c < NCH; c++) begin
         sum[c] = SUM_W'(upleft[c*CHAN_W +: CHAN_W]) + SUM_W'(up[c*CHAN_W +: CHAN_W]) +
                  SUM_W'(left[c*CHAN_W +: CHAN_W]) + SUM_W'(cur[c*CHAN_W +: CHAN_W]);
         avg[c*CHAN_W +: CHAN_W] = sum[c][SUM_W-1:2];
         any_set = any_set | (sum[c] != '0);
      end
      result = (interior && any_set) ? avg : pixel;
   end

endmodule

>>> design/masked_box_blur_2x2.sv
// masked 2x2 box blur top level: stage pipeline around the line memory
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_pixel_rgb, req_mask_value
//  rsp      out        rsp_valid / rsp_stall  rsp_pixel_out
//  csr      in         csr_wr_en              csr_index, csr_wr_data
//
// one pixel per clock sustained while rsp is not stalled; a result passes from
// the window stage, which covers the registered line memory read, into the
// output register, which offers it on rsp.
// reset restores 640x480 and the counters; the line memory is not cleared.
// a stall on rsp holds the output register, then the window stage, then req.
module masked_box_blur_2x2 (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [mbb_pkg::PIX_W-1:0]   req_pixel_rgb,
   input  logic [mbb_pkg::MASK_W-1:0]  req_mask_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mbb_pkg::PIX_W-1:0]   rsp_pixel_out,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [mbb_pkg::CSR_W-1:0]   csr_wr_data
);
   import mbb_pkg::*;

   pos_type          pos;
   logic             req_accept;
   logic             s1_adv;
   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [PIX_W-1:0] s1_masked_ff;
   logic             s1_interior_ff;
   logic [COL_W-1:0] s1_idx_ff;
   logic [PIX_W-1:0] up;
   logic [PIX_W-1:0] left_ff;
   logic [PIX_W-1:0] upleft_ff;
   logic [PIX_W-1:0] result;
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_pixel_ff;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   mbb_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .advance     (req_accept),
      .pos         (pos)
   );

   // the window stage writes its masked pixel back as it leaves
   mbb_line_mem u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (pos.idx),
      .rd_data (up),
      .wr_en   (s1_adv),
      .wr_addr (s1_idx_ff),
      .wr_data (s1_masked_ff)
   );

   mbb_blur u_blur (
      .upleft   (upleft_ff),
      .up       (up),
      .left     (left_ff),
      .cur      (s1_masked_ff),
      .pixel    (s1_pixel_ff),
      .interior (s1_interior_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff    <= req_pixel_rgb;
         s1_masked_ff   <= (req_mask_value == MASK_PASS) ? req_pixel_rgb : '0;
         s1_interior_ff <= pos.interior;
         s1_idx_ff      <= pos.idx;
      end
      if (s1_adv) begin
         rsp_pixel_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
         upleft_ff    <= '0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            left_ff      <= s1_masked_ff;
            upleft_ff    <= up;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

endmodule

>>> design/mbb_checker.sv
// port-level checks for the masked 2x2 box blur, bound to the top level
module mbb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [mbb_pkg::PIX_W-1:0]   rsp_pixel_out
);
   import mbb_pkg::*;

   // output register comes up empty
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // a held result does not change
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out))
      else $error("stalled result changed");

   // once a transaction has passed the window stage, the output register is full
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("result missing two cycles after transaction");

   // an empty output register never backs up the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled while output empty");

endmodule

bind masked_box_blur_2x2 mbb_checker u_mbb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_pixel_out (rsp_pixel_out)
);
